// ----- hdl/slpwm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpwm_pkg: shared types and constants for the slew-limited PWM setpoints
// Field widths, reset values, operation and register codes, sequencer states.
// ----------------------------------------------------------------------------
package slpwm_pkg;

  localparam int MAX_CH    = 8;
  localparam int OP_W      = 2;
  localparam int PULSE_W   = 16;
  localparam int PER_A_W   = 16;
  localparam int PER_W     = 24;
  localparam int PER1_W    = PER_W + 1;
  localparam int TICK_W    = 24;
  localparam int PROD_W    = PULSE_W + PER1_W;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CHAN_W    = 3;

  localparam logic [PULSE_W-1:0] RST_MIN    = 16'd1000;
  localparam logic [PULSE_W-1:0] RST_MAX    = 16'd2000;
  localparam logic [PULSE_W-1:0] RST_NEU    = 16'd1500;
  localparam logic [PULSE_W-1:0] RST_STEP   = 16'd10;
  localparam logic [PULSE_W-1:0] RST_FRAME  = 16'd2500;
  localparam logic [PULSE_W-1:0] RST_PULSE  = 16'd1500;
  localparam logic [PER_W-1:0]   RST_PERIOD = 24'd2999;

  localparam logic [TICK_W-1:0]  TICK_SAT   = '1;

  typedef enum logic [OP_W-1:0] {
    OP_SET     = 2'd0,
    OP_TICK    = 2'd1,
    OP_NEUTRAL = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN   = 3'd0,
    REG_MAX   = 3'd1,
    REG_NEU   = 3'd2,
    REG_STEP  = 3'd3,
    REG_FRAME = 3'd4,
    REG_PER_A = 3'd5,
    REG_PER_B = 3'd6,
    REG_PER_C = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_DIV_START,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

// ----- hdl/slpwm_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpwm_div: saturating restoring divider, one quotient bit per cycle
// Divides the pulse-period product by the frame length into a 24-bit value.
// ----------------------------------------------------------------------------
module slpwm_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [slpwm_pkg::PROD_W-1:0]   dividend,
  input  logic [slpwm_pkg::PULSE_W-1:0]  divisor,
  output logic                           done,
  output logic [slpwm_pkg::TICK_W-1:0]   quotient
);
  import slpwm_pkg::*;

  localparam int CNT_W = $clog2(TICK_W + 1);

  logic                 active;
  logic [CNT_W-1:0]     cnt;
  logic [PULSE_W-1:0]   rem;
  logic [TICK_W-1:0]    acc;
  logic [PULSE_W:0]     trial;
  logic [PULSE_W:0]     diff;
  logic                 ge;
  logic                 sat;

  // Quotient overflows 24 bits exactly when the top part already reaches the
  // divisor; a zero divisor lands here too.
  assign sat   = dividend[PROD_W-1:TICK_W] >= {{(PROD_W-TICK_W-PULSE_W){1'b0}}, divisor};
  assign trial = {rem, acc[TICK_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
      done   <= 1'b0;
    end else begin
      if (start) begin
        if (sat) begin
          acc    <= TICK_SAT;
          done   <= 1'b1;
          active <= 1'b0;
        end else begin
          rem    <= dividend[TICK_W+PULSE_W-1:TICK_W];
          acc    <= dividend[TICK_W-1:0];
          cnt    <= CNT_W'(TICK_W);
          active <= 1'b1;
          done   <= 1'b0;
        end
      end else if (active) begin
        // shift in next dividend bit, subtract when it fits
        rem  <= ge ? diff[PULSE_W-1:0] : trial[PULSE_W-1:0];
        acc  <= {acc[TICK_W-2:0], ge};
        cnt  <= cnt - 1'b1;
        done <= (cnt == CNT_W'(1));
        if (cnt == CNT_W'(1)) begin
          active <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign quotient = acc;

endmodule

// ----- hdl/slew_limited_pwm_setpoints_unit.sv -----
`timescale 1ns / 1ps
// A set item or an unused op code gives no transaction. A tick or neutral item
// scans the channels and runs one transaction per flagged channel (scan, multiply,
// divider load, bit-serial divide, output load); a saturated quotient skips the divide.
// One item at a time: in_stall holds off the next until the scan ends; the shared
// bit-serial divider and output stalls set the rate.
// Reset: synchronous, clears the sequencer, loads register defaults, sets pulses to 1500.
// ----------------------------------------------------------------------------
// slew_limited_pwm_setpoints_unit: slew-limited thruster PWM setpoints
// Keeps target and current pulse widths per channel, slews current toward
// target on each tick and converts moved pulses, or all on neutral, into timer compare values.
// ----------------------------------------------------------------------------
module slew_limited_pwm_setpoints_unit #(
  parameter int CHANNELS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [slpwm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [slpwm_pkg::CFG_W-1:0]     cfg_data,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [slpwm_pkg::OP_W-1:0]      op,
  input  logic [slpwm_pkg::PULSE_W-1:0]   pulse_0,
  input  logic [slpwm_pkg::PULSE_W-1:0]   pulse_1,
  input  logic [slpwm_pkg::PULSE_W-1:0]   pulse_2,
  input  logic [slpwm_pkg::PULSE_W-1:0]   pulse_3,
  input  logic [slpwm_pkg::PULSE_W-1:0]   pulse_4,
  input  logic [slpwm_pkg::PULSE_W-1:0]   pulse_5,
  input  logic [slpwm_pkg::PULSE_W-1:0]   pulse_6,
  input  logic [slpwm_pkg::PULSE_W-1:0]   pulse_7,
  // output channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [slpwm_pkg::CHAN_W-1:0]    chan,
  output logic [slpwm_pkg::TICK_W-1:0]    compare_ticks,
  output logic [slpwm_pkg::PULSE_W-1:0]   applied_pulse_us,
  output logic                            last
);
  import slpwm_pkg::*;

  // Never more than eight channels are served, even for a larger CHANNELS.
  localparam int ACTIVE = (CHANNELS < MAX_CH) ? CHANNELS : MAX_CH;
  localparam int IDX_W  = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
  localparam int CNT_W  = $clog2(ACTIVE + 1);
  localparam logic [CNT_W-1:0] CH_END = CNT_W'(ACTIVE);

  // Configuration registers
  logic [PULSE_W-1:0] reg_min;
  logic [PULSE_W-1:0] reg_max;
  logic [PULSE_W-1:0] reg_neu;
  logic [PULSE_W-1:0] reg_step;
  logic [PULSE_W-1:0] reg_frame;
  logic [PER_A_W-1:0] reg_per_a;
  logic [PER_W-1:0]   reg_per_b;
  logic [PER_W-1:0]   reg_per_c;

  // Per-channel state
  logic [PULSE_W-1:0] target  [ACTIVE];
  logic [PULSE_W-1:0] current [ACTIVE];

  // Sequencer
  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   ch;
  logic [IDX_W-1:0]   ch_idx;
  logic [ACTIVE-1:0]  mask;
  logic [ACTIVE-1:0]  chg;
  logic [PULSE_W-1:0] pulse_reg;
  logic [PROD_W-1:0]  prod;

  // Combinational helpers
  logic [PULSE_W-1:0] pulse_in [MAX_CH];
  logic               accept;
  logic               out_free;
  logic               div_start;
  logic               div_done;
  logic [TICK_W-1:0]  div_q;
  logic [PULSE_W-1:0] cur_c;
  logic [PULSE_W-1:0] cur_t;
  logic [PULSE_W-1:0] gap;
  logic [PULSE_W-1:0] move;
  logic [PULSE_W-1:0] slewed;
  logic [PER_W-1:0]   period;
  logic [PER1_W-1:0]  per1;
  logic [PROD_W-1:0]  prod_calc;
  logic               later;

  function automatic logic [PULSE_W-1:0] clamp(input logic [PULSE_W-1:0] v,
                                               input logic [PULSE_W-1:0] lo,
                                               input logic [PULSE_W-1:0] hi);
    logic [PULSE_W-1:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign pulse_in[0] = pulse_0;
  assign pulse_in[1] = pulse_1;
  assign pulse_in[2] = pulse_2;
  assign pulse_in[3] = pulse_3;
  assign pulse_in[4] = pulse_4;
  assign pulse_in[5] = pulse_5;
  assign pulse_in[6] = pulse_6;
  assign pulse_in[7] = pulse_7;

  assign ch_idx   = ch[IDX_W-1:0];
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  // output slot can take a new transaction when empty or draining this cycle
  assign out_free = !out_valid || !out_stall;

  // Slew one channel: step toward target by at most the step limit.
  // Equal values give a zero gap and leave the pulse untouched.
  always_comb begin
    cur_c = current[ch_idx];
    cur_t = target[ch_idx];
    if (cur_c < cur_t) begin
      gap = cur_t - cur_c;
    end else begin
      gap = cur_c - cur_t;
    end
    move = (gap > reg_step) ? reg_step : gap;
    if (cur_c < cur_t) begin
      slewed = cur_c + move;
    end else begin
      slewed = cur_c - move;
    end
  end

  // A channel moves on a tick exactly when it is off target and the step is
  // nonzero, so the whole result set is known at acceptance.
  always_comb begin
    for (int i = 0; i < ACTIVE; i++) begin
      chg[i] = (current[i] != target[i]) && (reg_step != '0);
    end
  end

  // Flag the final transaction: no marked channel left above this one.
  always_comb begin
    later = 1'b0;
    for (int i = 0; i < ACTIVE; i++) begin
      if (mask[i] && (int'(ch) < i)) begin
        later = 1'b1;
      end
    end
  end

  // Timer group select: channels 0-1 group a, 2-3 group b, the rest group c.
  always_comb begin
    if (int'(ch) < 2) begin
      period = PER_W'(reg_per_a);
    end else if (int'(ch) < 4) begin
      period = reg_per_b;
    end else begin
      period = reg_per_c;
    end
  end

  assign per1      = {1'b0, period} + PER1_W'(1);
  assign prod_calc = PROD_W'(pulse_reg) * PROD_W'(per1);

  // Shared divider: product / frame, saturated to 24 bits
  slpwm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (reg_frame),
    .done     (div_done),
    .quotient (div_q)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and sequencer outputs
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && ((op == OP_TICK) || (op == OP_NEUTRAL))) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (ch == CH_END) begin
          state_next = ST_IDLE;
        end else if (mask[ch_idx]) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_DIV_START;
      end
      ST_DIV_START: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_SCAN;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Datapath and state storage
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_min   <= RST_MIN;
      reg_max   <= RST_MAX;
      reg_neu   <= RST_NEU;
      reg_step  <= RST_STEP;
      reg_frame <= RST_FRAME;
      reg_per_a <= PER_A_W'(RST_PERIOD);
      reg_per_b <= RST_PERIOD;
      reg_per_c <= RST_PERIOD;
      for (int i = 0; i < ACTIVE; i++) begin
        target[i]  <= RST_PULSE;
        current[i] <= RST_PULSE;
      end
      ch        <= '0;
      mask      <= '0;
      out_valid <= 1'b0;
    end else begin
      // Register writes must arrive only while idle; the block itself does not enforce this.
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_MIN:   reg_min   <= cfg_data[PULSE_W-1:0];
          REG_MAX:   reg_max   <= cfg_data[PULSE_W-1:0];
          REG_NEU:   reg_neu   <= cfg_data[PULSE_W-1:0];
          REG_STEP:  reg_step  <= cfg_data[PULSE_W-1:0];
          REG_FRAME: reg_frame <= cfg_data[PULSE_W-1:0];
          REG_PER_A: reg_per_a <= cfg_data[PER_A_W-1:0];
          REG_PER_B: reg_per_b <= cfg_data[PER_W-1:0];
          REG_PER_C: reg_per_c <= cfg_data[PER_W-1:0];
          default: begin
          end
        endcase
      end

      // Drop the held transaction once taken, unless a new one loads below.
      if (out_valid && !out_stall && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (op)
              OP_SET: begin
                for (int i = 0; i < ACTIVE; i++) begin
                  target[i] <= clamp(pulse_in[i], reg_min, reg_max);
                end
              end
              OP_TICK: begin
                mask <= chg;
                ch   <= '0;
              end
              OP_NEUTRAL: begin
                // Current equals target afterwards, so the scan reports the
                // neutral value on every channel.
                for (int i = 0; i < ACTIVE; i++) begin
                  target[i]  <= reg_neu;
                  current[i] <= reg_neu;
                end
                mask <= '1;
                ch   <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (ch != CH_END) begin
            if (mask[ch_idx]) begin
              current[ch_idx] <= slewed;
              pulse_reg       <= slewed;
            end else begin
              ch <= ch + 1'b1;
            end
          end
        end
        ST_MUL: begin
          prod <= prod_calc;
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            chan             <= CHAN_W'(ch);
            compare_ticks    <= div_q;
            applied_pulse_us <= pulse_reg;
            last             <= !later;
            ch               <= ch + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Divider completion only lands while the sequencer waits for it.
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider done outside wait state");

  // Channel counter never runs past the end marker.
  a_ch_range: assert property (@(posedge clk) disable iff (rst)
    ch <= CH_END)
    else $error("channel counter out of range");

  // Only channels flagged at acceptance produce a transaction.
  a_out_marked: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |-> mask[ch_idx])
    else $error("result for unflagged channel");

  // A blocked output slot holds the sequencer in the output state.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_OUT) && out_valid && out_stall) |=> (state == ST_OUT))
    else $error("result loaded over a pending transaction");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for slew_limited_pwm_setpoints_unit
// Feeds set, tick, neutral and unused commands through the input handshake and keeps
// its own copy of the per-channel target and current pulse widths. From that
// copy it predicts each compare write and checks the writes in order, under
// random and long back-pressure and across several register settings.
// ----------------------------------------------------------------------------
module tb;
  import slpwm_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 12;
  // A tick with no write still keeps the sequencer busy while it scans
  // all eight channels, so wait well past that before writing registers or
  // stopping.
  localparam int QUIET_CYCLES = 300;
  localparam int HOLD_CYCLES  = 1500;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int MAX_REPORTS  = 40;
  localparam int PHASE_CMDS   = 21;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]                op;
    logic [MAX_CH-1:0][PULSE_W-1:0] pulse;
  } thruster_cmd_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  chan;
    logic [TICK_W-1:0]  ticks;
    logic [PULSE_W-1:0] pulse;
    logic               last;
  } compare_write_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [OP_W-1:0]      op;
  logic [PULSE_W-1:0]   pulse_0, pulse_1, pulse_2, pulse_3;
  logic [PULSE_W-1:0]   pulse_4, pulse_5, pulse_6, pulse_7;
  logic                 out_valid;
  logic                 out_stall;
  logic [CHAN_W-1:0]    chan;
  logic [TICK_W-1:0]    compare_ticks;
  logic [PULSE_W-1:0]   applied_pulse_us;
  logic                 last;

  slew_limited_pwm_setpoints_unit dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .op(op),
    .pulse_0(pulse_0), .pulse_1(pulse_1), .pulse_2(pulse_2), .pulse_3(pulse_3),
    .pulse_4(pulse_4), .pulse_5(pulse_5), .pulse_6(pulse_6), .pulse_7(pulse_7),
    .out_valid(out_valid), .out_stall(out_stall), .chan(chan),
    .compare_ticks(compare_ticks), .applied_pulse_us(applied_pulse_us), .last(last)
  );

  // Shadow copy of the registers and the channel state.
  logic [PULSE_W-1:0] lo_us, hi_us, rest_us, step_us, frame_len, period_a;
  logic [PER_W-1:0]   period_b, period_c;
  logic [PULSE_W-1:0] target_us  [MAX_CH];
  logic [PULSE_W-1:0] current_us [MAX_CH];

  thruster_cmd_t  command_queue [$];
  compare_write_t expected_compares [$];
  thruster_cmd_t  on_bus;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_on       = 1'b0;
  int hold_count    = 0;
  int cycle_count   = 0;
  int commands_accepted = 0;
  int compares_checked  = 0;
  int settings_loaded   = 0;
  int mismatches        = 0;

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // Compare value for one channel: exact product, then divide and saturate.
  function automatic logic [TICK_W-1:0] compare_for(int ch, logic [PULSE_W-1:0] p);
    logic [PER1_W-1:0] span;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] quot;
    if (ch < 2) span = PER1_W'(period_a) + 1'b1;
    else if (ch < 4) span = PER1_W'(period_b) + 1'b1;
    else span = PER1_W'(period_c) + 1'b1;
    if (frame_len == '0) return TICK_SAT;
    prod = PROD_W'(p) * PROD_W'(span);
    quot = prod / PROD_W'(frame_len);
    return (quot > PROD_W'(TICK_SAT)) ? TICK_SAT : quot[TICK_W-1:0];
  endfunction

  task automatic queue_compare(int ch, logic [PULSE_W-1:0] p);
    compare_write_t w;
    w.chan  = CHAN_W'(ch);
    w.ticks = compare_for(ch, p);
    w.pulse = p;
    w.last  = 1'b0;
    expected_compares.push_back(w);
  endtask

  // Advance the shadow state by one accepted command and queue its writes.
  task automatic predict_command(thruster_cmd_t c);
    logic [PULSE_W-1:0] moved;
    logic [PULSE_W-1:0] gap;
    compare_write_t     tail;
    int                 made;
    made = 0;
    case (c.op)
      OP_SET: begin
        for (int i = 0; i < MAX_CH; i++) begin
          if (c.pulse[i] < lo_us) target_us[i] = lo_us;
          else if (c.pulse[i] > hi_us) target_us[i] = hi_us;
          else target_us[i] = c.pulse[i];
        end
      end
      OP_TICK: begin
        for (int i = 0; i < MAX_CH; i++) begin
          moved = current_us[i];
          if (moved < target_us[i]) begin
            gap   = target_us[i] - moved;
            moved = moved + ((gap > step_us) ? step_us : gap);
          end else if (moved > target_us[i]) begin
            gap   = moved - target_us[i];
            moved = moved - ((gap > step_us) ? step_us : gap);
          end
          if (moved != current_us[i]) begin
            current_us[i] = moved;
            queue_compare(i, moved);
            made++;
          end
        end
      end
      OP_NEUTRAL: begin
        for (int i = 0; i < MAX_CH; i++) begin
          current_us[i] = rest_us;
          target_us[i]  = rest_us;
          queue_compare(i, rest_us);
          made++;
        end
      end
      default: ;  // unused op code: drop it
    endcase
    if (made > 0) begin
      tail = expected_compares.pop_back();
      tail.last = 1'b1;
      expected_compares.push_back(tail);
    end
  endtask

  // Driver: predict on acceptance, then offer the next command or idle.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      op       <= '0;
      pulse_0  <= '0;
      pulse_1  <= '0;
      pulse_2  <= '0;
      pulse_3  <= '0;
      pulse_4  <= '0;
      pulse_5  <= '0;
      pulse_6  <= '0;
      pulse_7  <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_command(on_bus);
        commands_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (command_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = command_queue.pop_front();
          in_valid <= 1'b1;
          op       <= on_bus.op;
          pulse_0  <= on_bus.pulse[0];
          pulse_1  <= on_bus.pulse[1];
          pulse_2  <= on_bus.pulse[2];
          pulse_3  <= on_bus.pulse[3];
          pulse_4  <= on_bus.pulse[4];
          pulse_5  <= on_bus.pulse[5];
          pulse_6  <= on_bus.pulse[6];
          pulse_7  <= on_bus.pulse[7];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure: one long hold when asked, random stalls otherwise.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_on && hold_count < HOLD_CYCLES) begin
      out_stall  <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic flag_field(string what, longint unsigned want, longint unsigned got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
  endtask

  // Monitor: check every output transaction against the oldest expectation.
  always @(posedge clk) begin
    compare_write_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_compares.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected transaction chan %0d ticks %0d pulse %0d last %0d",
                   $time, chan, compare_ticks, applied_pulse_us, last);
      end else begin
        want = expected_compares.pop_front();
        compares_checked++;
        if (chan !== want.chan) flag_field("chan", want.chan, chan);
        if (compare_ticks !== want.ticks) flag_field("compare_ticks", want.ticks, compare_ticks);
        if (applied_pulse_us !== want.pulse)
          flag_field("applied_pulse_us", want.pulse, applied_pulse_us);
        if (last !== want.last) flag_field("last", want.last, last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d writes outstanding",
               cycle_count, expected_compares.size());
      $display("slew_limited_pwm_setpoints_unit: mismatch");
      $finish;
    end
  end

  // Register write: present at one edge, committed at the next.
  task automatic program_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_MIN:   lo_us     = val[PULSE_W-1:0];
      REG_MAX:   hi_us     = val[PULSE_W-1:0];
      REG_NEU:   rest_us   = val[PULSE_W-1:0];
      REG_STEP:  step_us   = val[PULSE_W-1:0];
      REG_FRAME: frame_len = val[PULSE_W-1:0];
      REG_PER_A: period_a  = val[PER_A_W-1:0];
      REG_PER_B: period_b  = val[PER_W-1:0];
      REG_PER_C: period_c  = val[PER_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(logic [15:0] lo, logic [15:0] hi, logic [15:0] neu,
                               logic [15:0] step, logic [15:0] frame, logic [15:0] pa,
                               logic [23:0] pb, logic [23:0] pc);
    program_reg(REG_MIN, CFG_W'(lo));
    program_reg(REG_MAX, CFG_W'(hi));
    program_reg(REG_NEU, CFG_W'(neu));
    program_reg(REG_STEP, CFG_W'(step));
    program_reg(REG_FRAME, CFG_W'(frame));
    program_reg(REG_PER_A, CFG_W'(pa));
    program_reg(REG_PER_B, pb);
    program_reg(REG_PER_C, pc);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  task automatic random_settings(bit keep_moving);
    logic [15:0] lo, hi, neu, step, frame;
    lo = 16'($urandom_range(2500));
    hi = 16'(lo + $urandom_range(2000));
    if ($urandom_range(5) == 0) hi = 16'($urandom_range(lo));  // window inverted
    neu = ($urandom_range(1) != 0) ? 16'($urandom) : 16'($urandom_range(2200, 800));
    case ($urandom_range(7))
      0:       step = keep_moving ? 16'd1 : 16'd0;
      1:       step = 16'hFFFF;
      default: step = 16'($urandom_range(400, 1));
    endcase
    case ($urandom_range(9))
      0:       frame = 16'd0;
      1, 2, 3: frame = 16'($urandom_range(65535, 1));
      default: frame = 16'($urandom_range(20000, 1000));
    endcase
    load_settings(lo, hi, neu, step, frame, 16'($urandom),
                  ($urandom_range(1) != 0) ? 24'($urandom) : 24'($urandom_range(40000)),
                  ($urandom_range(1) != 0) ? 24'($urandom) : 24'($urandom_range(40000)));
  endtask

  task automatic push_cmd(logic [OP_W-1:0] o, logic [MAX_CH-1:0][PULSE_W-1:0] p);
    thruster_cmd_t c;
    c.op    = o;
    c.pulse = p;
    command_queue.push_back(c);
  endtask

  // Mostly ticks after sets so currents keep chasing targets; pulses land
  // near the clamp window most of the time.
  function automatic thruster_cmd_t random_cmd();
    thruster_cmd_t c;
    int unsigned   pick, lo_b, hi_b;
    pick = $urandom_range(99);
    if (pick < 30) c.op = OP_SET;
    else if (pick < 86) c.op = OP_TICK;
    else if (pick < 95) c.op = OP_NEUTRAL;
    else c.op = OP_UNUSED;
    lo_b = (lo_us < hi_us) ? lo_us : hi_us;
    hi_b = (lo_us < hi_us) ? hi_us : lo_us;
    lo_b = (lo_b > 300) ? lo_b - 300 : 0;
    hi_b = (hi_b + 300 > 65535) ? 65535 : hi_b + 300;
    for (int i = 0; i < MAX_CH; i++)
      c.pulse[i] = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(hi_b, lo_b));
    return c;
  endfunction

  task automatic random_phase(int send_pct, int recv_pct, bit long_hold);
    thruster_cmd_t c;
    int            counted;
    counted = 0;
    @(negedge clk);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    hold_on       = long_hold;
    while (counted < PHASE_CMDS) begin
      c = random_cmd();
      command_queue.push_back(c);
      if (c.op != OP_UNUSED) counted++;
    end
  endtask

  // Wait for every command to go in and every write to come out, then let
  // any command with no writes finish.
  task automatic settle();
    do @(negedge clk);
    while (command_queue.size() != 0 || in_valid || expected_compares.size() != 0);
    repeat (QUIET_CYCLES) @(negedge clk);
    hold_on = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    lo_us = RST_MIN; hi_us = RST_MAX; rest_us = RST_NEU; step_us = RST_STEP;
    frame_len = RST_FRAME; period_a = RST_PERIOD[PER_A_W-1:0];
    period_b = RST_PERIOD; period_c = RST_PERIOD;
    for (int i = 0; i < MAX_CH; i++) begin
      target_us[i]  = RST_PULSE;
      current_us[i] = RST_PULSE;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults, no idling. Pulse lists run from channel 7 down to 0.
    push_cmd(OP_TICK, '0);          // at rest: nothing moves, no writes
    push_cmd(OP_UNUSED, '1);        // unused op code gives nothing
    push_cmd(OP_SET, {16'd65535, 16'd0, 16'd999, 16'd1000,
                      16'd2000, 16'd2001, 16'd1500, 16'd1234});
    repeat (3) push_cmd(OP_TICK, '0);
    push_cmd(OP_NEUTRAL, '0);
    push_cmd(OP_SET, {8{16'h5555}});
    push_cmd(OP_TICK, '0);
    settle();

    // Widest window, full-scale step and periods, unit frame: saturation.
    load_settings(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'hFFFF,
                  24'hFFFFFF, 24'hFFFFFF);
    push_cmd(OP_SET, {16'd0, 16'd65535, 16'd1, 16'd65534,
                      16'd32768, 16'd0, 16'd65535, 16'd12345});
    push_cmd(OP_TICK, '0);
    push_cmd(OP_TICK, '0);
    push_cmd(OP_NEUTRAL, '0);
    push_cmd(OP_SET, '0);
    push_cmd(OP_TICK, '0);
    settle();

    // Largest frame with zero periods: tiny compare values, unit step.
    load_settings(16'd0, 16'hFFFF, 16'd0, 16'd1, 16'hFFFF, 16'd0, 24'd0, 24'd0);
    push_cmd(OP_SET, {4{16'hFFFF, 16'd1}});
    push_cmd(OP_TICK, '0);
    push_cmd(OP_TICK, '0);
    push_cmd(OP_NEUTRAL, '0);
    settle();

    // Min above max, zero step, zero frame.
    load_settings(16'd3000, 16'd1000, 16'd1200, 16'd0, 16'd0, 16'd2999,
                  24'd2999, 24'd2999);
    push_cmd(OP_SET, {16'd0, 16'd999, 16'd1000, 16'd2999,
                      16'd3000, 16'd3001, 16'd65535, 16'd1500});
    push_cmd(OP_TICK, '0);
    push_cmd(OP_NEUTRAL, '0);
    push_cmd(OP_SET, {16'd3001, 16'd0, 16'd3001, 16'd0, 16'd3001, 16'd0, 16'd3001, 16'd0});
    push_cmd(OP_TICK, '0);
    settle();

    // Random part: fresh settings per phase, each idling mix in turn.
    random_settings(1'b0);
    random_phase(0, 0, 1'b0);
    settle();
    random_settings(1'b0);
    random_phase(57, 0, 1'b0);
    settle();
    random_settings(1'b0);
    random_phase(0, 57, 1'b0);
    settle();
    random_settings(1'b0);
    random_phase(23, 23, 1'b0);
    settle();
    // Hold the output long while commands keep coming, so the input backs up.
    random_settings(1'b1);
    random_phase(0, 23, 1'b1);
    settle();

    $display("%0d commands over %0d register settings, %0d compare writes checked",
             commands_accepted, settings_loaded, compares_checked);
    $display("covered clamping, inverted window, zero step, zero frame, saturation, %0d-cycle hold",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("slew_limited_pwm_setpoints_unit: match");
    end else begin
      $display("slew_limited_pwm_setpoints_unit: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/slpwm_pkg.sv
hdl/slpwm_div.sv
hdl/slew_limited_pwm_setpoints_unit.sv
test/tb.sv
